[design/assert_macros.svh]
// Assertion macros shared by the coder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of aclk while reset is released.
`define SNDX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a trigger is followed in the next cycle by a condition.
`define SNDX_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

[design/sndx_pkg.sv]
// Shared constants, types and the letter class table of the code stream unit.
package sndx_pkg;

    // Number of characters in one complete code.
    localparam int CODE_LENGTH = 4;
    // Width of a count that runs from zero up to CODE_LENGTH.
    localparam int CNT_W = $clog2(CODE_LENGTH + 1);

    // ASCII characters that the coder produces.
    localparam logic [7:0] CH_NONE = 8'h00;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_6    = 8'h36;

    // One job handed from the front end to the emitter: the first character
    // to send, how many characters to send, and the code position to start at.
    typedef struct packed {
        logic [7:0]       ch;
        logic [CNT_W-1:0] remain;
        logic [CNT_W-1:0] base;
    } job_t;

    // Consonant class digit of a lower-case letter, or CH_NONE when the byte
    // belongs to no class.
    function automatic logic [7:0] class_digit(input logic [7:0] b);
        logic [7:0] d;
        case (b)
            "b", "f", "p", "v":                     d = CH_1;
            "c", "g", "j", "k", "q", "s", "x", "z": d = CH_2;
            "d", "t":                               d = CH_3;
            "l":                                    d = CH_4;
            "m", "n":                               d = CH_5;
            "r":                                    d = CH_6;
            default:                                d = CH_NONE;
        endcase
        return d;
    endfunction

endpackage

[design/sndx_front.sv]
// Input register, word state and per-item classification of the coder.
`include "assert_macros.svh"

module sndx_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] in_byte
    input  logic             s_tlast,
    output logic             job_valid,
    input  logic             job_ready,
    output sndx_pkg::job_t   job
);
    import sndx_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic [CNT_W-1:0] emit_cnt_reg;
    logic [CNT_W-1:0] emit_cnt_next;
    logic [1:0]       word_pos_reg;
    logic [1:0]       word_pos_next;
    logic [7:0]       prev_byte_reg;
    logic [7:0]       prev_byte_next;
    logic             consume;
    logic             first;
    logic             collapsed;
    logic [7:0]       digit;
    logic             char_valid;
    logic [CNT_W-1:0] cnt_after;

    assign consume  = in_valid_reg && job_ready;
    assign s_tready = !in_valid_reg || job_ready;

    // Input register: holds one item until the emitter takes its job.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Classify the held byte against the word state.
    always_comb begin
        first      = (word_pos_reg == 2'd0);
        collapsed  = (word_pos_reg == 2'd2) && (in_byte_reg == prev_byte_reg);
        digit      = class_digit(in_byte_reg);
        if (first) begin
            char_valid = 1'b1;
        end else begin
            char_valid = (emit_cnt_reg < CNT_W'(CODE_LENGTH)) && !collapsed
                         && (digit != CH_NONE);
        end
        cnt_after  = emit_cnt_reg + {{(CNT_W-1){1'b0}}, char_valid};
        job.ch     = !char_valid ? CH_0 : (first ? in_byte_reg : digit);
        job.base   = emit_cnt_reg;
        // The last byte fills the code up to its full length with padding.
        if (in_last_reg) begin
            job.remain = CNT_W'(CODE_LENGTH) - emit_cnt_reg;
        end else begin
            job.remain = {{(CNT_W-1){1'b0}}, char_valid};
        end
    end

    assign job_valid = in_valid_reg;

    // Next word state; the last byte of a word clears it.
    always_comb begin
        if (in_last_reg) begin
            emit_cnt_next  = '0;
            word_pos_next  = 2'd0;
            prev_byte_next = 8'h00;
        end else begin
            emit_cnt_next  = cnt_after;
            word_pos_next  = (word_pos_reg == 2'd2) ? 2'd2 : word_pos_reg + 2'd1;
            prev_byte_next = in_byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_cnt_reg  <= '0;
            word_pos_reg  <= 2'd0;
            prev_byte_reg <= 8'h00;
        end else if (consume) begin
            emit_cnt_reg  <= emit_cnt_next;
            word_pos_reg  <= word_pos_next;
            prev_byte_reg <= prev_byte_next;
        end
    end

    `SNDX_ASSERT(a_cnt_range, emit_cnt_reg <= CNT_W'(CODE_LENGTH),
        "code count beyond code length")
    `SNDX_ASSERT_NEXT(a_word_clear, consume && in_last_reg,
        (word_pos_reg == 2'd0) && (emit_cnt_reg == '0), "word state not cleared")
    `SNDX_ASSERT(a_job_fit, !in_valid_reg ||
        ({1'b0, job.base} + {1'b0, job.remain} <= (CNT_W+1)'(CODE_LENGTH)),
        "job overruns the code length")

endmodule

[design/sndx_emit.sv]
// Emitter: sends a job's characters one per cycle, while the result register has room, into it.
`include "assert_macros.svh"

module sndx_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_ready,
    input  sndx_pkg::job_t   job,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] code_byte
    output logic             m_tlast
);
    import sndx_pkg::*;

    logic [7:0]       ch_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] base_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;
    logic             out_load;
    logic             emit;
    logic             job_load;

    assign out_load  = !m_valid_reg || m_tready;
    assign emit      = (rem_reg != '0) && out_load;
    assign job_ready = (rem_reg == '0) ||
                       ((rem_reg == CNT_W'(1)) && out_load);
    assign job_load  = job_valid && job_ready;

    // Job registers: after the first character only padding follows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (job_load) begin
            rem_reg <= job.remain;
        end else if (emit) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            ch_reg   <= job.ch;
            base_reg <= job.base;
        end else if (emit) begin
            ch_reg   <= CH_0;
            base_reg <= base_reg + CNT_W'(1);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= ch_reg;
            m_last_reg <= (base_reg == CNT_W'(CODE_LENGTH - 1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `SNDX_ASSERT(a_rem_range, rem_reg <= CNT_W'(CODE_LENGTH),
        "pending character count beyond code length")
    `SNDX_ASSERT(a_pos_fit, (rem_reg == '0) ||
        ({1'b0, base_reg} + {1'b0, rem_reg} <= (CNT_W+1)'(CODE_LENGTH)),
        "emitter position overruns the code length")
    `SNDX_ASSERT_NEXT(a_emit_shows, emit, m_valid_reg,
        "emitted character missing from result register")

endmodule

[design/soundex_code_stream_unit.sv]
// Top level of the Soundex-style code stream unit.
//
// The input channel (s_) takes one lower-case character per item, with
// s_tlast high on the final character of a word. The result channel (m_)
// gives the code as ASCII characters: the word's first byte unchanged, then
// class digits '1' to '6', padded with '0' at the word's end to four
// characters; m_tlast marks the fourth character.
// An accepted item passes an input register, the word logic, a job register
// and the result register. Items that give zero or one character flow at
// one item per cycle while the receiver keeps m_tready high. The last item
// of a word gives up to four characters, and the emitter sends them one per
// cycle while the result register has room, so it holds the next item back
// until it is sending the last of them.
// Reset (aresetn low at a clock edge) clears the word state and empties all
// stages. When the receiver holds m_tready low, the result holds, the stages
// behind it fill, and s_tready falls once no stage has room.
module soundex_code_stream_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] code_byte
    output logic       m_tlast
);
    import sndx_pkg::*;

    logic job_valid;
    logic job_ready;
    job_t job;

    // Input register and word state.
    sndx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // Character sequencing and result register.
    sndx_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[test/tb_soundex_code_stream_unit.sv]
// Self-checking testbench for the Soundex-style code stream unit.
module tb_soundex_code_stream_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sndx_pkg::*;

    // One code character as it leaves the result channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } code_item_t;

    // One row of directed stimulus. Rows with fixed set carry their expected
    // code characters (lowest byte first); other rows use the predictor.
    typedef struct packed {
        logic [7:0]      in_byte;
        logic            in_last;
        logic            fixed;
        logic [2:0]      n_codes;
        logic [3:0][7:0] codes;
        logic [3:0]      lasts;
    } stim_row_t;

    localparam int N_ROWS       = 25;
    localparam int RANDOM_ITEMS = 385;
    localparam int CALM_AFTER   = 330;
    localparam int PAUSE_AFTER  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] code_byte
    logic       m_tlast;

    // Predictor state for the word in progress.
    logic [CNT_W-1:0] code_count = '0;
    logic [1:0]       byte_pos   = '0;
    logic [7:0]       prior_byte = '0;

    code_item_t code_q[$];
    int         err_count   = 0;
    int         items_sent  = 0;
    bit         calm        = 1'b0;
    bit         rx_hold_req = 1'b0;
    bit         rx_holding  = 1'b0;

    // Words: zero and all-ones single-byte words, a repeated second letter,
    // a code that fills before the word ends, collapse of letters and of
    // non-letters, upper case, zero byte and the remaining classes.
    stim_row_t word_table [N_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 3'd4, {CH_0, CH_0, CH_0, 8'h00}, 4'b1000},
        '{8'hFF, 1'b1, 1'b1, 3'd4, {CH_0, CH_0, CH_0, 8'hFF}, 4'b1000},
        '{"b",   1'b0, 1'b1, 3'd1, {24'h0, 8'h62},            4'b0000},
        '{"b",   1'b1, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"b",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"c",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"d",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"l",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"m",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"r",   1'b1, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"k",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"t",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"t",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"A",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{8'h00, 1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"g",   1'b1, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"e",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"w",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"%",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"%",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"h",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"r",   1'b1, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"v",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"j",   1'b0, 1'b0, 3'd0, 32'h0, 4'h0},
        '{"s",   1'b1, 1'b0, 3'd0, 32'h0, 4'h0}
    };

    soundex_code_stream_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Consonant class of a byte; zero when it belongs to no class.
    function automatic logic [7:0] letter_class(input logic [7:0] b);
        case (b)
            "b", "f", "p", "v":                     return CH_1;
            "c", "g", "j", "k", "q", "s", "x", "z": return CH_2;
            "d", "t":                               return CH_3;
            "l":                                    return CH_4;
            "m", "n":                               return CH_5;
            "r":                                    return CH_6;
            default:                                return CH_NONE;
        endcase
    endfunction

    // Appends one code character and marks it when the code is complete.
    function automatic void put_code(inout code_item_t [CODE_LENGTH-1:0] outs,
                                     inout int n, input logic [7:0] ch);
        code_count = code_count + 1'b1;
        outs[n]    = '{ch, code_count == CNT_W'(CODE_LENGTH)};
        n++;
    endfunction

    // Advances the word state by one byte and gives the code characters it causes.
    function automatic void code_step(input logic [7:0] b, input logic l,
                                      output code_item_t [CODE_LENGTH-1:0] outs,
                                      output int n);
        logic [7:0] digit;
        n    = 0;
        outs = '0;
        if (byte_pos == 2'd0) begin
            put_code(outs, n, b);
        end else if (code_count < CNT_W'(CODE_LENGTH)) begin
            // From the third byte on, a repeat of the byte before is dropped.
            if (!(byte_pos == 2'd2 && b == prior_byte)) begin
                digit = letter_class(b);
                if (digit != CH_NONE) begin
                    put_code(outs, n, digit);
                end
            end
        end
        prior_byte = b;
        if (byte_pos != 2'd2) begin
            byte_pos = byte_pos + 1'b1;
        end
        // The word's last byte pads the code with zeros and starts over.
        if (l) begin
            while (code_count < CNT_W'(CODE_LENGTH)) begin
                put_code(outs, n, CH_0);
            end
            code_count = '0;
            byte_pos   = '0;
            prior_byte = '0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Offers one item, waits for its acceptance, then queues its expected code.
    task automatic send_item(input stim_row_t row);
        code_item_t [CODE_LENGTH-1:0] outs;
        int                           n;
        s_tvalid <= 1'b1;
        s_tdata  <= row.in_byte;
        s_tlast  <= row.in_last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        code_step(row.in_byte, row.in_last, outs, n);
        if (row.fixed) begin
            for (int i = 0; i < row.n_codes; i++) begin
                code_q.push_back('{row.codes[i], row.lasts[i]});
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                code_q.push_back(outs[i]);
            end
        end
    endtask

    // Drops the valid for a random burst when idling is allowed.
    task automatic sender_gap(input bit idle_on);
        if (idle_on && !calm && !rx_holding && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // Mostly lower-case letters, some repeats of the byte before, some any byte.
    function automatic logic [7:0] pick_byte(input logic [7:0] prev, input bit noisy);
        int r;
        r = $urandom_range(0, 99);
        if (noisy || r >= 85) begin
            return 8'($urandom_range(0, 255));
        end else if (r < 15) begin
            return prev;
        end
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    task automatic wait_for_codes();
        while (code_q.size() != 0) @(posedge aclk);
    endtask

    // Compare every accepted code character with the oldest expectation.
    always @(posedge aclk) begin
        code_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (code_q.size() == 0) begin
                report_mismatch($sformatf("unexpected code item %h last %b",
                                          m_tdata, m_tlast));
            end else begin
                want = code_q.pop_front();
                if (m_tdata !== want.ch) begin
                    report_mismatch($sformatf("code_byte %h, want %h", m_tdata, want.ch));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch($sformatf("code_last %b, want %b for %h",
                                              m_tlast, want.last, want.ch));
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and always ready at the end.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req && !hold_done) begin
                rx_holding = 1'b1;
                m_tready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_holding = 1'b0;
                hold_done  = 1'b1;
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 25)) @(posedge aclk);
            end
        end
    end

    // Sender: reset, directed words, then random words until enough items.
    initial begin
        stim_row_t  row;
        logic [7:0] prev;
        int         word_len;
        bit         noisy;
        bit         idle_on;
        bit         paused;
        int         waited;

        paused = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            send_item(word_table[i]);
            sender_gap(1'b1);
        end

        // Let the directed words drain fully before the random part.
        s_tvalid <= 1'b0;
        wait_for_codes();
        items_sent = 0;

        // Hold the receiver off early on while the sender keeps offering items.
        rx_hold_req = 1'b1;
        prev = 8'h00;
        while (items_sent < RANDOM_ITEMS) begin
            noisy    = ($urandom_range(0, 9) == 0);
            idle_on  = ($urandom_range(0, 2) != 0);
            word_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8);
            if (noisy) begin
                word_len = $urandom_range(1, 6);
            end
            for (int k = 0; k < word_len; k++) begin
                row         = '0;
                prev        = pick_byte(prev, noisy);
                row.in_byte = prev;
                row.in_last = (k == word_len - 1);
                send_item(row);
                sender_gap(idle_on);
            end
            if (items_sent >= CALM_AFTER) begin
                calm = 1'b1;
            end
            // Once, pause on a word boundary until every code has come out.
            if (!paused && items_sent >= PAUSE_AFTER) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                wait_for_codes();
            end
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (code_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (code_q.size() != 0) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            repeat (20) @(posedge aclk);
            if (err_count == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
            $finish;
        end
    end

    // Watchdog for a run that hangs.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/sndx_pkg.sv
design/sndx_front.sv
design/sndx_emit.sv
design/soundex_code_stream_unit.sv
test/tb_soundex_code_stream_unit.sv
